@@ hw/rtl/sap_pkg.sv @@
package sap_pkg;

  // Build-time sizing.
  localparam int MAX_STAGES  = 16;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 16;
  localparam int CNT_REG_W   = 5;
  localparam int FRAC_BITS   = 15;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  localparam int IDX_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_STAGES + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int ACC_W  = SAMPLE_BITS + 4;

  // APB register map.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [GAIN_W-1:0]    MIX_RESET    = 16'h8000;
  localparam logic [CNT_REG_W-1:0] STAGES_RESET = 5'd4;

  typedef enum logic [1:0] {
    REG_ALLPASS_COEF  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_MIX_GAIN      = 2'd2,
    REG_STAGE_COUNT   = 2'd3
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef struct packed {
    gain_t                 allpass_coef;
    gain_t                 feedback_gain;
    logic [GAIN_W-1:0]     mix_gain;
    logic [CNT_REG_W-1:0]  stage_count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    gain_t             coef;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

  localparam acc_t SAT_HI = {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam acc_t SAT_LO = {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Scale a Q1.15 product back by 2^-15, rounding half up.
  function automatic acc_t round_q15(input prod_t p);
    prod_t t;
    t = p + PROD_W'(ROUND_HALF);
    return ACC_W'(t >>> FRAC_BITS);
  endfunction

  // Clamp to the signed sample range.
  function automatic sample_t sat_sample(input acc_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sap_in_if.sv @@
interface sap_in_if;
  import sap_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_left;
  sample_t in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink (input valid, input in_left, input in_right, output ready);
endinterface

@@ hw/rtl/sap_out_if.sv @@
interface sap_out_if;
  import sap_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

@@ hw/rtl/sap_lane.sv @@
module sap_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sap_pkg::lane_ctl_t    ctl,
  input  sap_pkg::sample_t      x_in,
  output sap_pkg::lane_stat_t   stat,
  output sap_pkg::sample_t      y_out
);
  import sap_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_ACC  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  sample_t          cur_r, cur_nxt;
  prod_t            prod_r, prod_nxt;

  // Per-stage history for this channel.
  sample_t xprev_r [MAX_STAGES];
  sample_t yprev_r [MAX_STAGES];

  diff_t            diff;
  sample_t          acc_sat;
  logic [CNT_W-1:0] cnt_m1;
  logic             last;

  always_comb begin
    diff    = DIFF_W'(yprev_r[idx_r]) - DIFF_W'(cur_r);
    acc_sat = sat_sample(ACC_W'(xprev_r[idx_r]) + round_q15(prod_r));
    cnt_m1  = ctl.count - CNT_W'(1);
    last    = (CNT_W'(idx_r) == cnt_m1);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          cur_nxt   = x_in;
          idx_nxt   = '0;
          state_nxt = (ctl.count == '0) ? L_DONE : L_MUL;
        end
      end
      L_MUL: begin
        prod_nxt  = PROD_W'(diff) * PROD_W'(ctl.coef);
        state_nxt = L_ACC;
      end
      L_ACC: begin
        cur_nxt = acc_sat;
        if (last) begin
          state_nxt = L_DONE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = L_MUL;
        end
      end
      L_DONE: begin
        state_nxt = L_IDLE;
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      idx_r   <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        xprev_r[i] <= '0;
        yprev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (state_r == L_ACC) begin
        xprev_r[idx_r] <= cur_r;
        yprev_r[idx_r] <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prod_r <= prod_nxt;
  end

  assign stat.done = (state_r == L_DONE);
  assign y_out     = cur_r;

endmodule

@@ hw/rtl/sap_mix.sv @@
module sap_mix (
  input  logic                  clk,
  input  logic                  rst_n,
  sap_in_if.sink                in_ch,
  sap_out_if.source             out_ch,
  input  sap_pkg::cfg_t         cfg,
  output sap_pkg::lane_ctl_t    lane_ctl,
  output sap_pkg::sample_t      wet_in_l,
  output sap_pkg::sample_t      wet_in_r,
  input  sap_pkg::lane_stat_t   stat_l,
  input  sap_pkg::lane_stat_t   stat_r,
  input  sap_pkg::sample_t      wet_l,
  input  sap_pkg::sample_t      wet_r
);
  import sap_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_FBMUL = 5'b00010,
    M_FBADD = 5'b00100,
    M_LANES = 5'b01000,
    M_FIN   = 5'b10000
  } mix_state_t;

  mix_state_t state_r, state_nxt;
  sample_t    fb_r, fb_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    dry_l_r, dry_l_nxt, dry_r_r, dry_r_nxt;
  prod_t      prod_fb_r, prod_fb_nxt;
  prod_t      prod_ml_r, prod_ml_nxt, prod_mr_r, prod_mr_nxt;
  sample_t    out_l_r, out_l_nxt, out_r_r, out_r_nxt;

  acc_t                     fbterm;
  diff_t                    sum_lr;
  diff_t                    mean;
  diff_t                    dl, dr;
  logic signed [GAIN_W:0]   mix_s;
  logic                     out_free;
  logic [CNT_W-1:0]         count;

  always_comb begin
    fbterm   = round_q15(prod_fb_r);
    wet_in_l = sat_sample(ACC_W'(dry_l_r) + fbterm);
    wet_in_r = sat_sample(ACC_W'(dry_r_r) + fbterm);
    sum_lr   = DIFF_W'(wet_l) + DIFF_W'(wet_r) + DIFF_W'(1);
    mean     = sum_lr >>> 1;
    dl       = DIFF_W'(wet_l) - DIFF_W'(dry_l_r);
    dr       = DIFF_W'(wet_r) - DIFF_W'(dry_r_r);
    mix_s    = signed'({1'b0, cfg.mix_gain});
    out_free = !out_valid_r || out_ch.ready;
    if (int'(cfg.stage_count) > MAX_STAGES) begin
      count = CNT_W'(MAX_STAGES);
    end else begin
      count = CNT_W'(cfg.stage_count);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fb_nxt        = fb_r;
    dry_l_nxt     = dry_l_r;
    dry_r_nxt     = dry_r_r;
    prod_fb_nxt   = prod_fb_r;
    prod_ml_nxt   = prod_ml_r;
    prod_mr_nxt   = prod_mr_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    lane_ctl.start = 1'b0;
    lane_ctl.count = count;
    lane_ctl.coef  = cfg.allpass_coef;
    unique case (state_r)
      M_IDLE: begin
        if (in_ch.valid) begin
          dry_l_nxt = in_ch.in_left;
          dry_r_nxt = in_ch.in_right;
          state_nxt = M_FBMUL;
        end
      end
      M_FBMUL: begin
        prod_fb_nxt = PROD_W'(fb_r) * PROD_W'(cfg.feedback_gain);
        state_nxt   = M_FBADD;
      end
      M_FBADD: begin
        lane_ctl.start = 1'b1;
        state_nxt      = M_LANES;
      end
      M_LANES: begin
        if (stat_l.done && stat_r.done) begin
          prod_fb_nxt = PROD_W'(mean) * PROD_W'(cfg.feedback_gain);
          prod_ml_nxt = PROD_W'(dl) * PROD_W'(mix_s);
          prod_mr_nxt = PROD_W'(dr) * PROD_W'(mix_s);
          state_nxt   = M_FIN;
        end
      end
      M_FIN: begin
        if (out_free) begin
          fb_nxt        = sat_sample(round_q15(prod_fb_r));
          out_l_nxt     = sat_sample(ACC_W'(dry_l_r) + round_q15(prod_ml_r));
          out_r_nxt     = sat_sample(ACC_W'(dry_r_r) + round_q15(prod_mr_r));
          out_valid_nxt = 1'b1;
          state_nxt     = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dry_l_r   <= dry_l_nxt;
    dry_r_r   <= dry_r_nxt;
    prod_fb_r <= prod_fb_nxt;
    prod_ml_r <= prod_ml_nxt;
    prod_mr_r <= prod_mr_nxt;
    out_l_r   <= out_l_nxt;
    out_r_r   <= out_r_nxt;
  end

  assign in_ch.ready      = (state_r == M_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_l_r;
  assign out_ch.out_right = out_r_r;

endmodule

@@ hw/rtl/stereo_allpass_phaser_top.sv @@
// Each stereo pair runs through the feedback multiply, feedback add, lane and finish states;
// a new pair is taken only in the idle state. Each lane spends a multiply step and an
// accumulate step on every active allpass stage.
// The two channel lanes run in lockstep, so both finish on the same cycle.
// Reset (synchronous, rst_n low) clears all stage history and the feedback value,
// loads the register defaults and empties the output register; no clearing pass.
module stereo_allpass_phaser_top (
  input  logic                               clk,
  input  logic                               rst_n,
  sap_in_if.sink                             in_ch,
  sap_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sap_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sap_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sap_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import sap_pkg::*;

  // Configuration registers. Each register sits on a 32-bit word, so only
  // the word index bits of the address are decoded.
  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     apb_wr;

  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign apb_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.allpass_coef  <= '0;
      cfg_r.feedback_gain <= '0;
      cfg_r.mix_gain      <= MIX_RESET;
      cfg_r.stage_count   <= STAGES_RESET;
    end else if (apb_wr) begin
      unique case (reg_sel)
        REG_ALLPASS_COEF:  cfg_r.allpass_coef  <= pwdata[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: cfg_r.feedback_gain <= pwdata[GAIN_W-1:0];
        REG_MIX_GAIN:      cfg_r.mix_gain      <= pwdata[GAIN_W-1:0];
        REG_STAGE_COUNT:   cfg_r.stage_count   <= pwdata[CNT_REG_W-1:0];
      endcase
    end
  end

  // Register read-back, zero extended to the bus width.
  always_comb begin
    unique case (reg_sel)
      REG_ALLPASS_COEF:  prdata = {{(APB_DATA_W - GAIN_W){1'b0}}, cfg_r.allpass_coef};
      REG_FEEDBACK_GAIN: prdata = {{(APB_DATA_W - GAIN_W){1'b0}}, cfg_r.feedback_gain};
      REG_MIX_GAIN:      prdata = {{(APB_DATA_W - GAIN_W){1'b0}}, cfg_r.mix_gain};
      REG_STAGE_COUNT:   prdata = {{(APB_DATA_W - CNT_REG_W){1'b0}}, cfg_r.stage_count};
    endcase
  end

  // The sequencer applies the feedback term to both dry samples, starts
  // the lanes, then merges the two wet results into the new feedback value
  // and the wet/dry mix held in the output register.
  lane_ctl_t  lane_ctl;
  lane_stat_t lane_l_stat, lane_r_stat;
  sample_t    wet_in_l, wet_in_r;
  sample_t    wet_l, wet_r;

  sap_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg_r),
    .lane_ctl (lane_ctl),
    .wet_in_l (wet_in_l),
    .wet_in_r (wet_in_r),
    .stat_l   (lane_l_stat),
    .stat_r   (lane_r_stat),
    .wet_l    (wet_l),
    .wet_r    (wet_r)
  );

  // One lane per channel. Each lane walks its allpass cascade one stage at
  // a time with a single multiplier and keeps its own stage history.
  sap_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .x_in  (wet_in_l),
    .stat  (lane_l_stat),
    .y_out (wet_l)
  );

  sap_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .x_in  (wet_in_r),
    .stat  (lane_r_stat),
    .y_out (wet_r)
  );

  // After a transfer in, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item was in progress");

  // Both lanes share one control word and must finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_l_stat.done == lane_r_stat.done)
    else $error("channel lanes out of step");

  // A rising result valid is preceded by lane completion, with the finish state between them.
  a_result_follows_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(lane_l_stat.done, 2))
    else $error("result not preceded by lane completion");

endmodule

@@ tb/sv/phaser_check_pkg.sv @@
`timescale 1ns / 100ps

package phaser_check_pkg;
  import sap_pkg::*;

  localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  class phaser_tracker;
    longint       coef;
    longint       fb_gain;
    longint       mix;
    int unsigned  stages;
    longint       x_hist[2*MAX_STAGES];
    longint       y_hist[2*MAX_STAGES];
    longint       fb_val;
    stereo_pair_t due_pairs[$];
    int unsigned  failures;

    function new();
      for (int k = 0; k < 2*MAX_STAGES; k++) begin
        x_hist[k] = 0;
        y_hist[k] = 0;
      end
      fb_val   = 0;
      coef     = 0;
      fb_gain  = 0;
      mix      = longint'(MIX_RESET);
      stages   = 32'(STAGES_RESET);
      failures = 0;
    endfunction

    static function longint clip(longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
    endfunction

    // Q1.15 product, rounded half up (arithmetic shift gives the floor).
    static function longint scale(longint x, longint g);
      return (x * g + longint'(ROUND_HALF)) >>> FRAC_BITS;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_ALLPASS_COEF:  coef    = longint'($signed(v[15:0]));
        REG_FEEDBACK_GAIN: fb_gain = longint'($signed(v[15:0]));
        REG_MIX_GAIN:      mix     = longint'(v[15:0]);
        REG_STAGE_COUNT:   stages  = 32'(v[4:0]);
        default: ;
      endcase
    endfunction

    // Runs one stereo pair through the phaser and queues the mixed result.
    function void take_pair(sample_t l, sample_t r);
      longint       dry[2];
      longint       wet[2];
      longint       fbterm;
      longint       avg;
      longint       xin;
      longint       yout;
      int unsigned  n;
      int unsigned  k;
      stereo_pair_t res;
      n      = (stages > MAX_STAGES) ? MAX_STAGES : stages;
      dry[0] = longint'(l);
      dry[1] = longint'(r);
      fbterm = scale(fb_val, fb_gain);
      for (int ch = 0; ch < 2; ch++) wet[ch] = clip(dry[ch] + fbterm);
      for (int st = 0; st < n; st++) begin
        for (int ch = 0; ch < 2; ch++) begin
          k         = 2*st + ch;
          xin       = wet[ch];
          yout      = clip(x_hist[k] + scale(y_hist[k] - xin, coef));
          x_hist[k] = xin;
          y_hist[k] = yout;
          wet[ch]   = yout;
        end
      end
      avg       = (wet[0] + wet[1] + 1) >>> 1;
      fb_val    = clip(scale(avg, fb_gain));
      res.left  = sample_t'(clip(dry[0] + scale(wet[0] - dry[0], mix)));
      res.right = sample_t'(clip(dry[1] + scale(wet[1] - dry[1], mix)));
      due_pairs.push_back(res);
    endfunction

    function void note_failure(string what, longint want, longint got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: %0s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_pair(sample_t l, sample_t r);
      stereo_pair_t want;
      if (due_pairs.size() == 0) begin
        note_failure("result with nothing pending, left", 0, longint'(l));
        return;
      end
      want = due_pairs.pop_front();
      if (want.left !== l) note_failure("out_left", longint'(want.left), longint'(l));
      if (want.right !== r) note_failure("out_right", longint'(want.right), longint'(r));
    endfunction

    function int unsigned outstanding();
      return due_pairs.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sap_pkg::*;
  import phaser_check_pkg::*;

  // Cycles without any transfer or register access before the run is declared hung.
  // The longest legitimate quiet spell is the receiver hold-off below plus one
  // full-depth pass through the block and the drain pause.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 2*MAX_STAGES + 8;
  localparam int unsigned IDLE_PCT     = 29;

  localparam sample_t TOP_SAMPLE    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t BOTTOM_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sap_in_if  in_if();
  sap_out_if out_if();

  // Shared knobs for the traffic shapers. steady turns off random idling on both
  // sides; hold_req asks the receiver for one long hold-off.
  bit steady;
  bit hold_req;

  int unsigned quiet_cycles;

  phaser_tracker tracker = new();

  stereo_allpass_phaser_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every accepted input pair is fed to the predictor at the edge of its transfer.
  // Values are read in the active region, so they are the ones present at the edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) tracker.take_pair(in_if.in_left, in_if.in_right);
  end

  // Every result transfer is compared with the oldest predicted pair.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_pair(out_if.out_left, out_if.out_right);
  end

  // Hang detector: any transfer or register access restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: ready drops at random, never while steady is set. On request it holds
  // off for a long stretch, counted here, so the block backs up into its input.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one pair after a random number of idle cycles and returns at the edge of
  // its transfer. valid stays high when the next pair follows without a gap.
  task automatic send_pair(input sample_t l, input sample_t r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.in_left  <= l;
    in_if.in_right <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge that
  // ends the access cycle, since pready is always high. The predictor follows then.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, v);
  endtask

  task automatic configure(input logic [31:0] c, input logic [31:0] f, input logic [31:0] m,
                           input logic [31:0] s);
    reg_write(REG_ALLPASS_COEF, c);
    reg_write(REG_FEEDBACK_GAIN, f);
    reg_write(REG_MIX_GAIN, m);
    reg_write(REG_STAGE_COUNT, s);
  endtask

  // Stops offering, then waits for every predicted pair to come back plus the
  // DRAIN_CYCLES pause, so the block is idle for register writes.
  task automatic drain();
    @(posedge clk);
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Samples lean toward the rails and toward small values, where saturation and
  // rounding are most likely to go wrong; the rest is full-range noise.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return TOP_SAMPLE;
      1: return BOTTOM_SAMPLE;
      2: return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h7FFF;
      1: return 32'h8000;
      2: return 32'(int'($urandom_range(0, 4095)) - 2048) & 32'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_mix();
    case ($urandom_range(5))
      0: return 32'h0000;
      1: return 32'h8000;
      2: return 32'hFFFF;
      3: return $urandom_range(0, 32768);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Mostly in-range stage counts; now and then one above the built maximum.
  function automatic logic [31:0] pick_stages();
    if ($urandom_range(3) == 0) return $urandom_range(MAX_STAGES + 1, 31);
    return $urandom_range(0, MAX_STAGES);
  endfunction

  task automatic random_phase(input int unsigned items, input bit full_depth);
    configure(pick_gain(), pick_gain(), pick_mix(), full_depth ? MAX_STAGES : pick_stages());
    repeat (items) send_pair(pick_sample(), pick_sample());
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.in_left  = '0;
    in_if.in_right = '0;
    steady         = 1'b0;
    hold_req       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults after reset: plain four-stage cascade, fully wet, rails first.
    send_pair(TOP_SAMPLE, TOP_SAMPLE);
    send_pair(BOTTOM_SAMPLE, BOTTOM_SAMPLE);
    send_pair(TOP_SAMPLE, BOTTOM_SAMPLE);
    send_pair(BOTTOM_SAMPLE, TOP_SAMPLE);
    send_pair(sample_t'(0), sample_t'(0));
    send_pair(sample_t'(-1), sample_t'(1));
    drain();

    // No stages at all, mix past unity, gain extremes.
    configure(32'h7FFF, 32'h8000, 32'hFFFF, 0);
    send_pair(TOP_SAMPLE, BOTTOM_SAMPLE);
    send_pair(BOTTOM_SAMPLE, TOP_SAMPLE);
    send_pair(sample_t'(123456), sample_t'(-654321));
    send_pair(sample_t'(0), sample_t'(0));
    drain();

    // A stage count above the built maximum must behave as the maximum; fully dry.
    configure(32'h8000, 32'h7FFF, 32'h0000, 31);
    send_pair(TOP_SAMPLE, TOP_SAMPLE);
    send_pair(BOTTOM_SAMPLE, sample_t'(77));
    send_pair(sample_t'(-4000000), sample_t'(4000000));
    send_pair(sample_t'(1), sample_t'(-1));
    drain();

    // All stages with moderate feedback, then a short cascade, then all stages again:
    // the history of the stages left out meanwhile has to survive untouched.
    configure(32'h4000, 32'h2000, 32'h8000, MAX_STAGES);
    send_pair(TOP_SAMPLE, TOP_SAMPLE);
    send_pair(sample_t'(2500000), sample_t'(-300000));
    drain();
    reg_write(REG_STAGE_COUNT, 2);
    send_pair(sample_t'(-1000000), sample_t'(900000));
    send_pair(BOTTOM_SAMPLE, TOP_SAMPLE);
    send_pair(sample_t'(42), sample_t'(-42));
    drain();
    reg_write(REG_STAGE_COUNT, MAX_STAGES);
    send_pair(sample_t'(0), sample_t'(0));
    send_pair(sample_t'(5000), sample_t'(-5000));
    drain();

    // Random settings and samples. One phase runs without idling on either side;
    // another starts with a long receiver hold-off at full depth so the input stalls.
    random_phase(88, 1'b0);
    steady = 1'b1;
    random_phase(88, 1'b0);
    steady = 1'b0;
    random_phase(88, 1'b0);
    hold_req = 1'b1;
    random_phase(88, 1'b1);
    random_phase(88, 1'b0);
    random_phase(88, 1'b0);

    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ stereo_allpass_phaser_top.f @@
hw/rtl/sap_pkg.sv
hw/rtl/sap_in_if.sv
hw/rtl/sap_out_if.sv
hw/rtl/sap_lane.sv
hw/rtl/sap_mix.sv
hw/rtl/stereo_allpass_phaser_top.sv
tb/sv/phaser_check_pkg.sv
tb/sv/tb.sv
